/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL; clk and rst_n are taken from the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsv_to_rgb: implication check failed");

// Implication that checks a fixed number of cycles later.
`define ASSERT_DELAY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("hsv_to_rgb: delayed check failed");

`endif

/* hdl/h2r_pkg.sv */
// Types and constants for the HSV to RGB converter.
`timescale 1ns / 1ps

package h2r_pkg;

  typedef struct packed {
    logic [8:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
    logic [7:0] alpha_in;
  } hsv_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha_out;
  } rgb_out_t;

  typedef enum logic [2:0] {
    SEC_RED_YELLOW   = 3'd0,
    SEC_YELLOW_GREEN = 3'd1,
    SEC_GREEN_CYAN   = 3'd2,
    SEC_CYAN_BLUE    = 3'd3,
    SEC_BLUE_MAGENTA = 3'd4,
    SEC_MAGENTA_RED  = 3'd5
  } sector_t;

  localparam logic [8:0]  HUE_CIRCLE = 9'd360;
  localparam logic [5:0]  SECTOR_DEG = 6'd60;
  localparam logic [7:0]  FULL_SCALE = 8'd255;
  localparam logic [13:0] FRAC_SCALE = 14'd15300;

  // x/255 for 16-bit x: (x*257) >> 16, low by at most one
  localparam logic [8:0]  RECIP_FULL = 9'd257;
  localparam int          RECIP_FULL_SHIFT = 16;

  // y/15300 for 22-bit y: (y*RECIP_FRAC) >> 36, low by at most one
  localparam int          RECIP_SHIFT = 36;
  localparam logic [22:0] RECIP_FRAC =
    23'((64'd1 << RECIP_SHIFT) / 64'(FRAC_SCALE));

endpackage

/* hdl/hsv_to_rgb_converter.sv */
// HSV to RGB colour converter: five-stage pipeline, one pixel per clock.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
//   Input: drive in_data (hue 0..360 degrees, saturation, brightness, alpha)
//   and raise start. A transaction is taken at each rising edge with start
//   high and busy low. busy is held low: the pipeline never stalls, so a new
//   pixel may be issued every cycle.
//   Output: out_valid is high for exactly one cycle with out_data holding red,
//   green, blue and the copied alpha. The receiver cannot hold results off and
//   must take each one in that cycle.
//   Pipeline: a pixel taken at a rising edge passes through five register
//   stages before it appears on out_data. Throughput: one pixel per cycle, as every
//   stage advances on each clock and busy never rises.
//   Stages: hue wrap and sector split; s*rem products; v-scaled products and
//   p estimate; q/t reciprocal estimate and p correction; q/t correction and
//   channel permutation.
//   Reset: synchronous, active low; clears all stage valid bits, so pixels in
//   flight are dropped and no result follows until new transactions arrive.

module hsv_to_rgb_converter import h2r_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  hsv_in_t  in_data,
  output logic     out_valid,
  output rgb_out_t out_data
);

  // ---------------- stage 1: hue wrap, sector and remainder ----------------
  logic [8:0] hue_wrap;
  sector_t    s1_sec_nxt;
  logic [8:0] sec_base;
  logic [5:0] s1_rem_nxt;

  logic       s1_valid_r;
  sector_t    s1_sec_r;
  logic [5:0] s1_rem_r;
  logic [7:0] s1_sat_r;
  logic [7:0] s1_val_r;
  logic [7:0] s1_alpha_r;

  always_comb begin
    hue_wrap = (in_data.hue >= HUE_CIRCLE) ? in_data.hue - HUE_CIRCLE : in_data.hue;
  end

  always_comb begin
    if (hue_wrap >= 9'(5 * SECTOR_DEG)) begin
      s1_sec_nxt = SEC_MAGENTA_RED;
      sec_base   = 9'(5 * SECTOR_DEG);
    end else if (hue_wrap >= 9'(4 * SECTOR_DEG)) begin
      s1_sec_nxt = SEC_BLUE_MAGENTA;
      sec_base   = 9'(4 * SECTOR_DEG);
    end else if (hue_wrap >= 9'(3 * SECTOR_DEG)) begin
      s1_sec_nxt = SEC_CYAN_BLUE;
      sec_base   = 9'(3 * SECTOR_DEG);
    end else if (hue_wrap >= 9'(2 * SECTOR_DEG)) begin
      s1_sec_nxt = SEC_GREEN_CYAN;
      sec_base   = 9'(2 * SECTOR_DEG);
    end else if (hue_wrap >= 9'(SECTOR_DEG)) begin
      s1_sec_nxt = SEC_YELLOW_GREEN;
      sec_base   = 9'(SECTOR_DEG);
    end else begin
      s1_sec_nxt = SEC_RED_YELLOW;
      sec_base   = 9'd0;
    end
    s1_rem_nxt = 6'(hue_wrap - sec_base);
  end

  always_ff @(posedge clk) begin
    s1_sec_r   <= s1_sec_nxt;
    s1_rem_r   <= s1_rem_nxt;
    s1_sat_r   <= in_data.saturation;
    s1_val_r   <= in_data.brightness;
    s1_alpha_r <= in_data.alpha_in;
  end

  // ---------------- stage 2: saturation products ----------------
  logic [13:0] s2_sr_nxt;
  logic [13:0] s2_st_nxt;
  logic [15:0] s2_xp_nxt;

  logic        s2_valid_r;
  sector_t     s2_sec_r;
  logic [7:0]  s2_val_r;
  logic [7:0]  s2_alpha_r;
  logic [13:0] s2_sr_r;
  logic [13:0] s2_st_r;
  logic [15:0] s2_xp_r;

  always_comb begin
    s2_sr_nxt = 14'(s1_sat_r) * 14'(s1_rem_r);
    s2_st_nxt = 14'(s1_sat_r) * 14'(SECTOR_DEG - s1_rem_r);
    s2_xp_nxt = 16'(s1_val_r) * 16'(FULL_SCALE - s1_sat_r);
  end

  always_ff @(posedge clk) begin
    s2_sec_r   <= s1_sec_r;
    s2_val_r   <= s1_val_r;
    s2_alpha_r <= s1_alpha_r;
    s2_sr_r    <= s2_sr_nxt;
    s2_st_r    <= s2_st_nxt;
    s2_xp_r    <= s2_xp_nxt;
  end

  // ---------------- stage 3: brightness products, p estimate ----------------
  logic [21:0] s3_yq_nxt;
  logic [21:0] s3_yt_nxt;
  logic [24:0] p_scaled;

  logic        s3_valid_r;
  sector_t     s3_sec_r;
  logic [7:0]  s3_val_r;
  logic [7:0]  s3_alpha_r;
  logic [21:0] s3_yq_r;
  logic [21:0] s3_yt_r;
  logic [15:0] s3_xp_r;
  logic [7:0]  s3_estp_r;

  always_comb begin
    s3_yq_nxt = 22'(s2_val_r) * 22'(FRAC_SCALE - s2_sr_r);
    s3_yt_nxt = 22'(s2_val_r) * 22'(FRAC_SCALE - s2_st_r);
    p_scaled  = 25'(s2_xp_r) * 25'(RECIP_FULL);
  end

  always_ff @(posedge clk) begin
    s3_sec_r   <= s2_sec_r;
    s3_val_r   <= s2_val_r;
    s3_alpha_r <= s2_alpha_r;
    s3_yq_r    <= s3_yq_nxt;
    s3_yt_r    <= s3_yt_nxt;
    s3_xp_r    <= s2_xp_r;
    s3_estp_r  <= p_scaled[RECIP_FULL_SHIFT +: 8];
  end

  // ---------------- stage 4: q/t estimates, p correction ----------------
  logic [44:0] q_scaled;
  logic [44:0] t_scaled;
  logic [15:0] p_resid;
  logic [7:0]  s4_p_nxt;

  logic        s4_valid_r;
  sector_t     s4_sec_r;
  logic [7:0]  s4_val_r;
  logic [7:0]  s4_alpha_r;
  logic [21:0] s4_yq_r;
  logic [21:0] s4_yt_r;
  logic [7:0]  s4_estq_r;
  logic [7:0]  s4_estt_r;
  logic [7:0]  s4_p_r;

  always_comb begin
    q_scaled = 45'(s3_yq_r) * 45'(RECIP_FRAC);
    t_scaled = 45'(s3_yt_r) * 45'(RECIP_FRAC);
    p_resid  = s3_xp_r - 16'(s3_estp_r) * 16'(FULL_SCALE);
    s4_p_nxt = (p_resid >= 16'(FULL_SCALE)) ? s3_estp_r + 8'd1 : s3_estp_r;
  end

  always_ff @(posedge clk) begin
    s4_sec_r   <= s3_sec_r;
    s4_val_r   <= s3_val_r;
    s4_alpha_r <= s3_alpha_r;
    s4_yq_r    <= s3_yq_r;
    s4_yt_r    <= s3_yt_r;
    s4_estq_r  <= q_scaled[RECIP_SHIFT +: 8];
    s4_estt_r  <= t_scaled[RECIP_SHIFT +: 8];
    s4_p_r     <= s4_p_nxt;
  end

  // ---------------- stage 5: q/t correction, permutation ----------------
  // zero saturation needs no special path: p, q and t all equal v then
  logic [21:0] q_resid;
  logic [21:0] t_resid;
  logic [7:0]  q_val;
  logic [7:0]  t_val;
  rgb_out_t    out_data_nxt;

  logic        out_valid_r;
  rgb_out_t    out_data_r;

  always_comb begin
    q_resid = s4_yq_r - 22'(s4_estq_r) * 22'(FRAC_SCALE);
    t_resid = s4_yt_r - 22'(s4_estt_r) * 22'(FRAC_SCALE);
    q_val   = (q_resid >= 22'(FRAC_SCALE)) ? s4_estq_r + 8'd1 : s4_estq_r;
    t_val   = (t_resid >= 22'(FRAC_SCALE)) ? s4_estt_r + 8'd1 : s4_estt_r;
  end

  always_comb begin
    out_data_nxt.alpha_out = s4_alpha_r;
    case (s4_sec_r)
      SEC_RED_YELLOW: begin
        out_data_nxt.red   = s4_val_r;
        out_data_nxt.green = t_val;
        out_data_nxt.blue  = s4_p_r;
      end
      SEC_YELLOW_GREEN: begin
        out_data_nxt.red   = q_val;
        out_data_nxt.green = s4_val_r;
        out_data_nxt.blue  = s4_p_r;
      end
      SEC_GREEN_CYAN: begin
        out_data_nxt.red   = s4_p_r;
        out_data_nxt.green = s4_val_r;
        out_data_nxt.blue  = t_val;
      end
      SEC_CYAN_BLUE: begin
        out_data_nxt.red   = s4_p_r;
        out_data_nxt.green = q_val;
        out_data_nxt.blue  = s4_val_r;
      end
      SEC_BLUE_MAGENTA: begin
        out_data_nxt.red   = t_val;
        out_data_nxt.green = s4_p_r;
        out_data_nxt.blue  = s4_val_r;
      end
      default: begin
        out_data_nxt.red   = s4_val_r;
        out_data_nxt.green = s4_p_r;
        out_data_nxt.blue  = q_val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // ---------------- valid chain ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= start && !busy;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  assign busy      = 1'b0;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- assertions ----------------
  `ASSERT_DELAY(a_grey_passes, start && !busy && in_data.saturation == 8'd0, 5,
                out_valid && out_data.red == $past(in_data.brightness, 5) &&
                out_data.green == out_data.red && out_data.blue == out_data.red)
  `ASSERT_IMPL(a_alpha_follows, out_valid,
               $past(start, 5) && out_data.alpha_out == $past(in_data.alpha_in, 5))
  `ASSERT_IMPL(a_peak_is_value, out_valid,
               out_data.red == $past(in_data.brightness, 5) ||
               out_data.green == $past(in_data.brightness, 5) ||
               out_data.blue == $past(in_data.brightness, 5))

endmodule

/* verif/hsv_to_rgb_converter_test.sv */
// Self-checking testbench for the HSV to RGB colour converter.
`timescale 1ns / 1ps

module hsv_to_rgb_converter_test import h2r_pkg::*; ();

  localparam int STALL_LIMIT = 400;
  localparam int TAIL_CYCLES = 12;
  localparam int RANDOM_PIXELS = 650;

  typedef struct {
    hsv_in_t px;
    int      gap;
    bit      drain;
  } feed_item_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  hsv_in_t  in_data = '0;
  logic     out_valid;
  rgb_out_t out_data;

  feed_item_t pixel_feed[$];
  rgb_out_t   rgb_due[$];

  feed_item_t staged;
  bit         staged_ok = 1'b0;
  int         gap_left = 0;

  int accepted_cnt = 0;
  int outstanding = 0;
  int results_cnt = 0;
  int fail_count = 0;
  int idle_cycles = 0;
  int total_pixels = 0;
  int directed_cnt = 0;
  int grey_cnt = 0;
  int wrap_cnt = 0;

  hsv_to_rgb_converter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic rgb_out_t predict_rgb(hsv_in_t px);
    int unsigned h, s, v, rem, p, q, t;
    rgb_out_t c;
    h = px.hue;
    s = px.saturation;
    v = px.brightness;
    if (h >= HUE_CIRCLE) h -= HUE_CIRCLE;
    c.alpha_out = px.alpha_in;
    if (s == 0) begin
      c.red   = 8'(v);
      c.green = 8'(v);
      c.blue  = 8'(v);
    end else begin
      rem = h % SECTOR_DEG;
      p = (v * (FULL_SCALE - s)) / FULL_SCALE;
      q = (v * (FRAC_SCALE - s * rem)) / FRAC_SCALE;
      t = (v * (FRAC_SCALE - s * (SECTOR_DEG - rem))) / FRAC_SCALE;
      case (sector_t'(3'(h / SECTOR_DEG)))
        SEC_RED_YELLOW: begin
          c.red = 8'(v); c.green = 8'(t); c.blue = 8'(p);
        end
        SEC_YELLOW_GREEN: begin
          c.red = 8'(q); c.green = 8'(v); c.blue = 8'(p);
        end
        SEC_GREEN_CYAN: begin
          c.red = 8'(p); c.green = 8'(v); c.blue = 8'(t);
        end
        SEC_CYAN_BLUE: begin
          c.red = 8'(p); c.green = 8'(q); c.blue = 8'(v);
        end
        SEC_BLUE_MAGENTA: begin
          c.red = 8'(t); c.green = 8'(p); c.blue = 8'(v);
        end
        default: begin
          c.red = 8'(v); c.green = 8'(p); c.blue = 8'(q);
        end
      endcase
    end
    return c;
  endfunction

  task automatic queue_pixel(int h, int s, int v, int a, int gap, bit drain);
    feed_item_t it;
    it.px.hue        = 9'(h);
    it.px.saturation = 8'(s);
    it.px.brightness = 8'(v);
    it.px.alpha_in   = 8'(a);
    it.gap   = gap;
    it.drain = drain;
    if (s == 0) grey_cnt++;
    if (h > HUE_CIRCLE) wrap_cnt++;
    pixel_feed.insert(pixel_feed.size(), it);
  endtask

  // Driver: presents the next pixel once its gap has run out; a drain item also
  // waits until the pipeline has emptied.
  always @(posedge clk) begin
    logic nxt_start;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      nxt_start = start && busy;
      if (!nxt_start) begin
        if (!staged_ok && pixel_feed.size() > 0) begin
          staged = pixel_feed.pop_front();
          staged_ok = 1'b1;
          gap_left = staged.gap;
        end
        if (staged_ok) begin
          if (gap_left > 0) begin
            gap_left--;
          end else if (!(staged.drain && (start || outstanding != 0))) begin
            in_data <= staged.px;
            nxt_start = 1'b1;
            staged_ok = 1'b0;
          end
        end
      end
      start <= nxt_start;
    end
  end

  // Monitor: predicts on each accepted transaction, checks each result strobe.
  always @(posedge clk) begin
    rgb_out_t want;
    bit took, got;
    if (rst_n) begin
      took = start && !busy;
      got  = out_valid;
      if (took) rgb_due.insert(rgb_due.size(), predict_rgb(in_data));
      if (got) begin
        if (rgb_due.size() == 0) begin
          $error("unexpected result: red %0d green %0d blue %0d alpha %0d",
                 out_data.red, out_data.green, out_data.blue, out_data.alpha_out);
          fail_count++;
        end else begin
          want = rgb_due.pop_front();
          if (out_data.red !== want.red) begin
            $error("red mismatch: expected %0d, actual %0d", want.red, out_data.red);
            fail_count++;
          end
          if (out_data.green !== want.green) begin
            $error("green mismatch: expected %0d, actual %0d", want.green, out_data.green);
            fail_count++;
          end
          if (out_data.blue !== want.blue) begin
            $error("blue mismatch: expected %0d, actual %0d", want.blue, out_data.blue);
            fail_count++;
          end
          if (out_data.alpha_out !== want.alpha_out) begin
            $error("alpha_out mismatch: expected %0d, actual %0d",
                   want.alpha_out, out_data.alpha_out);
            fail_count++;
          end
        end
        results_cnt <= results_cnt + 1;
      end
      accepted_cnt <= accepted_cnt + int'(took);
      outstanding  <= outstanding + int'(took) - int'(got);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int h, s, v, gap;
    bit burst;
    // directed corners: sector edges, hue wrap, grey, black, tiny values
    queue_pixel(0,   255, 255, 0,   0, 0);
    queue_pixel(59,  255, 255, 255, 0, 0);
    queue_pixel(60,  255, 255, 2,   0, 0);
    queue_pixel(119, 1,   255, 3,   0, 0);
    queue_pixel(120, 255, 255, 4,   1, 0);
    queue_pixel(180, 255, 255, 5,   0, 0);
    queue_pixel(239, 254, 253, 6,   0, 0);
    queue_pixel(240, 255, 255, 7,   3, 0);
    queue_pixel(300, 255, 255, 8,   0, 0);
    queue_pixel(359, 255, 255, 9,   0, 0);
    queue_pixel(360, 255, 255, 170, 0, 0);
    queue_pixel(361, 200, 200, 85,  0, 0);
    queue_pixel(420, 255, 128, 10,  2, 0);
    queue_pixel(511, 255, 255, 1,   0, 0);
    queue_pixel(256, 170, 85,  128, 0, 0);
    queue_pixel(30,  0,   128, 11,  0, 0);
    queue_pixel(200, 0,   255, 12,  0, 0);
    queue_pixel(200, 0,   0,   13,  0, 0);
    queue_pixel(45,  255, 0,   14,  0, 0);
    queue_pixel(1,   1,   1,   15,  0, 0);
    queue_pixel(299, 128, 77,  16,  0, 0);
    queue_pixel(330, 255, 1,   254, 0, 0);
    directed_cnt = pixel_feed.size();

    burst = 1'b0;
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if ($urandom_range(0, 39) == 0) burst = !burst;
      gap = burst ? 0 : $urandom_range(0, 17);
      if ($urandom_range(0, 6) == 0) h = $urandom_range(361, 511);
      else h = $urandom_range(0, 360);
      case ($urandom_range(0, 9))
        0:       s = 0;
        1:       s = 255;
        default: s = $urandom_range(0, 255);
      endcase
      v = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 255);
      queue_pixel(h, s, v, $urandom_range(0, 255), gap,
                  i == 0 || i == RANDOM_PIXELS / 2 || $urandom_range(0, 99) == 0);
    end
    total_pixels = pixel_feed.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (accepted_cnt != total_pixels || outstanding > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (rgb_due.size() != 0) begin
      $error("%0d expected results never arrived", rgb_due.size());
      fail_count++;
    end

    $display("Converted %0d pixels (%0d directed): all six sectors, %0d grey, %0d hue past 360,",
             total_pixels, directed_cnt, grey_cnt, wrap_cnt);
    $display("random sender gaps with back-to-back bursts; %0d results checked.", results_cnt);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* hsv_to_rgb_converter.f */
+incdir+hdl
hdl/h2r_pkg.sv
hdl/hsv_to_rgb_converter.sv
verif/hsv_to_rgb_converter_test.sv
